// ===== src/dpq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the double-ended priority queue.
// No dependencies; imported by every other file of the block except dpq_ram.
package dpq_pkg;

	localparam int KEY_W = 24;
	localparam int VAL_W = 24;
	localparam int ACT_W = 2;
	localparam int ST_W  = 2;

	// action codes
	localparam logic [ACT_W-1:0] ACT_INSERT  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_POP_MAX = 2'd1;
	localparam logic [ACT_W-1:0] ACT_POP_MIN = 2'd2;

	// status codes
	localparam logic [ST_W-1:0] ST_POPPED = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL   = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_INS_CHK,
		S_SH_RD,
		S_SH_WR,
		S_INS_WR,
		S_POP_WAIT,
		S_EMIT
	} state_t;

	// logical index the RAM read port is aimed at
	typedef enum logic [1:0] {
		RD_MID,
		RD_MAX,
		RD_MIN,
		RD_SHIFT
	} rd_sel_t;

	typedef struct packed {
		logic            load;
		logic            rd_en;
		rd_sel_t         rd_sel;
		logic            srch_upd;
		logic            shift_init;
		logic            shift_wr;
		logic            ins_wr;
		logic            pop_max;
		logic            pop_min;
		logic            pend_set;
		logic [ST_W-1:0] st_code;
		logic            use_rdata;
		logic            emit;
	} cmd_t;

	typedef struct packed {
		logic [ACT_W-1:0] act;
		logic             empty;
		logic             full;
		logic             srch_done;
		logic             found;
		logic             shift_done;
		logic             out_free;
	} sts_t;

endpackage

// ===== src/dpq_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dpq_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== src/dpq_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the priority queue: sequences search, shift and pops.
// Depends on dpq_pkg.
module dpq_ctrl import dpq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output cmd_t cmd,
	input  sts_t sts
);

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (sts.act) inside
					ACT_INSERT: begin
						state_nxt = S_SRCH_RD;
					end
					ACT_POP_MAX, ACT_POP_MIN: begin
						if (sts.empty) begin
							cmd.pend_set = 1'b1;
							cmd.st_code  = ST_EMPTY;
							state_nxt    = S_EMIT;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = (sts.act == ACT_POP_MAX) ? RD_MAX : RD_MIN;
							state_nxt  = S_POP_WAIT;
						end
					end
					default: begin
						state_nxt = S_IDLE;
					end
				endcase
			end
			S_SRCH_RD: begin
				if (sts.srch_done) begin
					state_nxt = S_INS_CHK;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_MID;
					state_nxt  = S_SRCH_CMP;
				end
			end
			S_SRCH_CMP: begin
				cmd.srch_upd = 1'b1;
				state_nxt    = S_SRCH_RD;
			end
			S_INS_CHK: begin
				if (sts.found) begin
					state_nxt = S_IDLE;
				end else if (sts.full) begin
					cmd.pend_set = 1'b1;
					cmd.st_code  = ST_FULL;
					state_nxt    = S_EMIT;
				end else begin
					cmd.shift_init = 1'b1;
					state_nxt      = S_SH_RD;
				end
			end
			S_SH_RD: begin
				if (sts.shift_done) begin
					state_nxt = S_INS_WR;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_SHIFT;
					state_nxt  = S_SH_WR;
				end
			end
			S_SH_WR: begin
				cmd.shift_wr = 1'b1;
				state_nxt    = S_SH_RD;
			end
			S_INS_WR: begin
				cmd.ins_wr = 1'b1;
				state_nxt  = S_IDLE;
			end
			S_POP_WAIT: begin
				cmd.pend_set  = 1'b1;
				cmd.st_code   = ST_POPPED;
				cmd.use_rdata = 1'b1;
				if (sts.act == ACT_POP_MAX) begin
					cmd.pop_max = 1'b1;
				end else begin
					cmd.pop_min = 1'b1;
				end
				state_nxt = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

// ===== src/dpq_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the priority queue: circular sorted store, search bounds, output register.
// Depends on dpq_pkg and dpq_ram.
module dpq_datapath import dpq_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic [ACT_W-1:0]  action,
	input  logic [KEY_W-1:0]  prio_key,
	input  logic [VAL_W-1:0]  item_value,
	input  logic              out_stall,
	output logic              out_valid,
	output logic [ST_W-1:0]   status,
	output logic [VAL_W-1:0]  popped_value
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int DW = KEY_W + VAL_W;
	localparam logic [AW:0]   CAP_X  = (AW+1)'(CAPACITY);
	localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
	localparam logic [AW-1:0] HEAD_L = AW'(CAPACITY - 1);

	// item being worked on
	logic [ACT_W-1:0] act_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;

	// store bookkeeping: entry i of sorted order lives at (head + i) mod CAPACITY
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;

	logic [CW-1:0] lo_q, hi_q, idx_q;
	logic          found_q;

	logic [ST_W-1:0]  pend_st_q;
	logic [VAL_W-1:0] pend_val_q;

	logic             out_valid_q;
	logic [ST_W-1:0]  status_q;
	logic [VAL_W-1:0] popped_value_q;

	logic [CW:0]      mid_sum;
	logic [CW-1:0]    mid;
	logic [CW-1:0]    cnt_m1, idx_m1;
	logic [AW-1:0]    rd_ofs, wr_ofs;
	logic             wr_en;
	logic [AW-1:0]    wr_addr, rd_addr;
	logic [DW-1:0]    wr_data, rd_data;
	logic [KEY_W-1:0] rd_key;
	logic [VAL_W-1:0] rd_val;

	function automatic logic [AW-1:0] to_phys(input logic [AW-1:0] head,
			input logic [AW-1:0] ofs);
		logic [AW:0] sum;
		sum = {1'b0, head} + {1'b0, ofs};
		if (sum >= CAP_X) begin
			sum = sum - CAP_X;
		end
		return sum[AW-1:0];
	endfunction

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[CW:1];
	assign cnt_m1  = count_q - 1'b1;
	assign idx_m1  = idx_q - 1'b1;
	assign rd_key  = rd_data[DW-1:VAL_W];
	assign rd_val  = rd_data[VAL_W-1:0];

	always_comb begin
		case (cmd.rd_sel)
			RD_MID:   rd_ofs = mid[AW-1:0];
			RD_MAX:   rd_ofs = cnt_m1[AW-1:0];
			RD_MIN:   rd_ofs = '0;
			RD_SHIFT: rd_ofs = idx_m1[AW-1:0];
			default:  rd_ofs = '0;
		endcase
	end

	assign rd_addr = to_phys(head_q, rd_ofs);
	assign wr_ofs  = cmd.shift_wr ? idx_q[AW-1:0] : lo_q[AW-1:0];
	assign wr_addr = to_phys(head_q, wr_ofs);
	assign wr_en   = cmd.shift_wr | cmd.ins_wr;
	assign wr_data = cmd.shift_wr ? rd_data : {key_q, val_q};

	dpq_ram #(
		.WIDTH(DW),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (cmd.rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.ins_wr) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.pop_max) begin
				count_q <= cnt_m1;
			end else if (cmd.pop_min) begin
				count_q <= cnt_m1;
				head_q  <= (head_q == HEAD_L) ? '0 : head_q + 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working and payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q   <= action;
			key_q   <= prio_key;
			val_q   <= item_value;
			lo_q    <= '0;
			hi_q    <= count_q;
			found_q <= 1'b0;
		end
		if (cmd.srch_upd) begin
			if (rd_key < key_q) begin
				lo_q <= mid + 1'b1;
			end else begin
				hi_q <= mid;
			end
			if (rd_key == key_q) begin
				found_q <= 1'b1;
			end
		end
		if (cmd.shift_init) begin
			idx_q <= count_q;
		end else if (cmd.shift_wr) begin
			idx_q <= idx_m1;
		end
		if (cmd.pend_set) begin
			pend_st_q  <= cmd.st_code;
			pend_val_q <= cmd.use_rdata ? rd_val : '0;
		end
		if (cmd.emit) begin
			status_q       <= pend_st_q;
			popped_value_q <= pend_val_q;
		end
	end

	assign sts.act        = act_q;
	assign sts.empty      = (count_q == '0);
	assign sts.full       = (count_q == CAP_C);
	assign sts.srch_done  = (lo_q == hi_q);
	assign sts.found      = found_q;
	assign sts.shift_done = (idx_q == lo_q);
	assign sts.out_free   = !out_valid_q || !out_stall;

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign popped_value = popped_value_q;

endmodule

// ===== src/double_ended_priority_queue_unit.sv =====
`timescale 1ns / 1ps
// Top level of the double-ended priority queue: controller plus datapath.
// Depends on dpq_pkg, dpq_ctrl, dpq_datapath (and through it dpq_ram).
//
//  channel | handshake          | payload                        | dir
//  --------+--------------------+--------------------------------+-----
//  in      | in_valid/in_stall  | action, prio_key, item_value   | in
//  out     | out_valid/out_stall| status, popped_value           | out
//
// Storage: entries sit sorted in one RAM used as a ring (head pointer + count).
// A pop reads the max or min entry, then waits for the output register; an insert
// runs a binary search over the n stored entries, then shifts the m entries above
// the new key one at a time through the single RAM read port and writes the new entry.
// Reset clears count, head and the output beat; the RAM needs no clearing pass.
// A result beat waits in the output register under out_stall while the next
// input beat is already taken; a new result waits until that register frees.
module double_ended_priority_queue_unit import dpq_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [ACT_W-1:0] action,
	input  logic [KEY_W-1:0] prio_key,
	input  logic [VAL_W-1:0] item_value,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [ST_W-1:0]  status,
	output logic [VAL_W-1:0] popped_value
);

	cmd_t cmd;  // controller -> datapath
	sts_t sts;  // datapath -> controller

	// sequencer: one input beat at a time, from accept to done
	dpq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd     (cmd),
		.sts     (sts)
	);

	// store, search bounds, shift index and output register
	dpq_datapath #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.action      (action),
		.prio_key    (prio_key),
		.item_value  (item_value),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.status      (status),
		.popped_value(popped_value)
	);

endmodule

// ===== src/dpq_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the double-ended priority queue, bound to the top level.
// Depends on dpq_pkg.
module dpq_port_checks import dpq_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input logic [ST_W-1:0]  status,
	input logic [VAL_W-1:0] popped_value
);

	// a held output beat keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(popped_value))
		else $error("output beat changed while stalled");

	// only a successful pop carries a value
	a_zero_val: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_POPPED) |-> popped_value == '0)
		else $error("nonzero value on empty/full status");

	// one item in flight: the input closes right after a beat is taken
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second input beat taken while busy");

	// a result only appears from work in progress
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without an item in progress");

endmodule

bind double_ended_priority_queue_unit dpq_port_checks u_dpq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.status      (status),
	.popped_value(popped_value)
);

// ===== tb/dpq_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the double-ended priority queue: watches both channels, keeps a sorted
// shadow store, predicts each result beat and compares it field by field.
// Depends on dpq_pkg for widths and action/status codes.
module dpq_checker import dpq_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_stall,
	input  logic [ACT_W-1:0] action,
	input  logic [KEY_W-1:0] prio_key,
	input  logic [VAL_W-1:0] item_value,
	input  logic             out_valid,
	input  logic             out_stall,
	input  logic [ST_W-1:0]  status,
	input  logic [VAL_W-1:0] popped_value,
	output int               errors,
	output int               pending
);

	typedef struct packed {
		logic [ST_W-1:0]  st;
		logic [VAL_W-1:0] val;
	} pop_result_t;

	// shadow store, ascending keys, slot 0 = smallest
	logic [KEY_W-1:0] shadow_keys [CAPACITY];
	logic [VAL_W-1:0] shadow_vals [CAPACITY];
	int               shadow_fill;
	pop_result_t      result_q [$];

	task automatic apply_beat(input logic [ACT_W-1:0] a, input logic [KEY_W-1:0] k,
			input logic [VAL_W-1:0] v);
		int pos;
		pop_result_t r;
		pos = 0;
		case (a) inside
			ACT_INSERT: begin
				while (pos < shadow_fill && shadow_keys[pos] < k)
					pos++;
				// duplicate key is dropped silently, even when full
				if (pos < shadow_fill && shadow_keys[pos] == k)
					return;
				if (shadow_fill >= CAPACITY) begin
					r.st = ST_FULL;
					r.val = '0;
					result_q.push_back(r);
					return;
				end
				for (int i = shadow_fill; i > pos; i--) begin
					shadow_keys[i] = shadow_keys[i-1];
					shadow_vals[i] = shadow_vals[i-1];
				end
				shadow_keys[pos] = k;
				shadow_vals[pos] = v;
				shadow_fill++;
			end
			ACT_POP_MAX, ACT_POP_MIN: begin
				if (shadow_fill == 0) begin
					r.st = ST_EMPTY;
					r.val = '0;
				end else if (a == ACT_POP_MAX) begin
					shadow_fill--;
					r.st = ST_POPPED;
					r.val = shadow_vals[shadow_fill];
				end else begin
					r.st = ST_POPPED;
					r.val = shadow_vals[0];
					for (int i = 0; i < shadow_fill - 1; i++) begin
						shadow_keys[i] = shadow_keys[i+1];
						shadow_vals[i] = shadow_vals[i+1];
					end
					shadow_fill--;
				end
				result_q.push_back(r);
			end
			default: ;	// unused code, no effect
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		pop_result_t e;
		if (!arst_n) begin
			shadow_fill = 0;
			result_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			// output first: a result can never leave on the edge its request enters
			if (out_valid && !out_stall) begin
				if (result_q.size() == 0) begin
					$error("result beat with nothing expected: status=%0d popped_value=%0h",
						status, popped_value);
					errors++;
				end else begin
					e = result_q.pop_front();
					if (status !== e.st) begin
						$error("status: expected %0d, actual %0d", e.st, status);
						errors++;
					end
					if (popped_value !== e.val) begin
						$error("popped_value: expected %0h, actual %0h", e.val, popped_value);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall)
				apply_beat(action, prio_key, item_value);
			pending = result_q.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Top of the double-ended priority queue bench: clock, reset, request stimulus and
// result-side stall pattern, plus the verdict. Depends on dpq_pkg, dpq_checker and the block.
module testbench import dpq_pkg::*; ();

	localparam int CAPACITY    = 64;
	localparam int N_ITEMS     = 1950;
	// margin for the longest silent insert: a search and a shift of every stored entry, rounded up
	localparam int DRAIN_CYC   = 200;
	localparam int HOLD_CYC    = 600;
	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
	localparam logic [KEY_W-1:0] KEY_TOP    = '1;
	localparam logic [VAL_W-1:0] VAL_TOP    = '1;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [ACT_W-1:0] action;
	logic [KEY_W-1:0] prio_key;
	logic [VAL_W-1:0] item_value;
	logic             out_valid;
	logic             out_stall;
	logic [ST_W-1:0]  status;
	logic [VAL_W-1:0] popped_value;
	int               errors;
	int               pending;

	// shared between the sender and the receiver process
	logic             calm = 1'b0;	// no idling on either side while set
	int               hold_req = 0;	// bumped by the sender to ask for one long receiver hold

	int               beats_sent;
	logic [KEY_W-1:0] used_keys [$];	// recent insert keys, reused to hit duplicates

	always #4 clk = ~clk;

	double_ended_priority_queue_unit #(.CAPACITY(CAPACITY)) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.prio_key    (prio_key),
		.item_value  (item_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.popped_value(popped_value)
	);

	dpq_checker #(.CAPACITY(CAPACITY)) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.prio_key    (prio_key),
		.item_value  (item_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.popped_value(popped_value),
		.errors      (errors),
		.pending     (pending)
	);

	// Present one request beat from a falling edge and hold it until taken.
	// Random idle cycles go ahead of the beat; valid never looks at stall.
	task automatic send_beat(input logic [ACT_W-1:0] a, input logic [KEY_W-1:0] k,
			input logic [VAL_W-1:0] v);
		while (!calm && $urandom_range(99) < 37) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid   = 1'b1;
		action     = a;
		prio_key   = k;
		item_value = v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (a == ACT_INSERT) begin
			used_keys.push_back(k);
			if (used_keys.size() > CAPACITY)
				void'(used_keys.pop_front());
		end
		beats_sent++;
		@(negedge clk);
	endtask

	// Stop offering beats until every predicted result is back, then let any
	// trailing silent insert finish.
	task automatic wait_drained();
		in_valid = 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		@(negedge clk);
	endtask

	// Key mix: reused keys for duplicates, the two extremes, a narrow range that
	// collides often, and full-width random keys.
	function automatic logic [KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(99);
		if (r < 15 && used_keys.size() != 0)
			return used_keys[$urandom_range(used_keys.size() - 1)];
		if (r < 22)
			return ($urandom_range(1) != 0) ? KEY_TOP : '0;
		if (r < 35)
			return KEY_W'($urandom_range(127));
		return KEY_W'($urandom());
	endfunction

	function automatic logic [VAL_W-1:0] pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return '0;
		if (r < 10)
			return VAL_TOP;
		return VAL_W'($urandom());
	endfunction

	// Receiver side: random stall ~37% of cycles, none while calm, and one long
	// hold, counted down here from HOLD_CYC, when the sender asks for it.
	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYC - 1;
				out_stall = 1'b1;
			end else begin
				out_stall = !calm && ($urandom_range(99) < 37);
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		int plen;
		int ins_pct;
		int next_pause;
		logic hold_done;
		logic [ACT_W-1:0] a;

		arst_n     = 1'b0;
		in_valid   = 1'b0;
		action     = ACT_INSERT;
		prio_key   = '0;
		item_value = '0;
		beats_sent = 0;
		next_pause = 400;
		hold_done  = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// --- directed part ---
		// pops on an empty store
		send_beat(ACT_POP_MAX, KEY_TOP, VAL_TOP);
		send_beat(ACT_POP_MIN, '0, '0);
		// extremes of key and value
		send_beat(ACT_INSERT, '0, VAL_TOP);
		send_beat(ACT_INSERT, KEY_TOP, '0);
		send_beat(ACT_INSERT, 24'h800000, 24'h5A5A5A);
		// duplicate keys keep the old value
		send_beat(ACT_INSERT, '0, 24'h111111);
		send_beat(ACT_INSERT, KEY_TOP, 24'h222222);
		// unused action code changes nothing
		send_beat(ACT_UNUSED, 24'h7FFFFF, 24'hA5A5A5);
		send_beat(ACT_POP_MIN, KEY_TOP, VAL_TOP);
		send_beat(ACT_POP_MAX, '0, '0);
		send_beat(ACT_POP_MAX, '0, '0);
		send_beat(ACT_POP_MIN, '0, '0);
		// insert below, above and between existing keys, then drain both ends
		send_beat(ACT_INSERT, 24'h000100, 24'h000001);
		send_beat(ACT_INSERT, 24'h000300, 24'h000003);
		send_beat(ACT_INSERT, 24'h000200, 24'h000002);
		send_beat(ACT_INSERT, 24'h000050, 24'h000004);
		send_beat(ACT_INSERT, 24'h000400, 24'h000005);
		send_beat(ACT_POP_MAX, '0, '0);
		send_beat(ACT_POP_MIN, '0, '0);
		send_beat(ACT_POP_MIN, '0, '0);
		send_beat(ACT_POP_MAX, '0, '0);
		send_beat(ACT_POP_MIN, '0, '0);
		send_beat(ACT_POP_MIN, '0, '0);
		wait_drained();

		// --- random part: phases that fill, drain or churn the store ---
		while (beats_sent < N_ITEMS) begin
			plen = $urandom_range(120, 20);
			case ($urandom_range(2))
				0: ins_pct = 85;	// fill: reaches full, full rejects, dup into full
				1: ins_pct = 15;	// drain: runs into empty pops
				default: ins_pct = 50;
			endcase
			repeat (plen) begin
				calm = (beats_sent >= 600 && beats_sent < 800);
				if ($urandom_range(99) < 3)
					a = ACT_UNUSED;
				else if ($urandom_range(99) < ins_pct)
					a = ACT_INSERT;
				else
					a = ($urandom_range(1) != 0) ? ACT_POP_MAX : ACT_POP_MIN;
				send_beat(a, pick_key(), pick_value());
			end
			calm = 1'b0;

			// once: receiver holds off while results pile up and the input backs up
			if (!hold_done && beats_sent >= 1000) begin
				hold_done = 1'b1;
				hold_req++;
				repeat (40) begin
					if ($urandom_range(99) < 70)
						a = ($urandom_range(1) != 0) ? ACT_POP_MAX : ACT_POP_MIN;
					else
						a = ACT_INSERT;
					send_beat(a, pick_key(), pick_value());
				end
			end

			// sender pause until every result has come back
			if (beats_sent >= next_pause) begin
				next_pause += 400;
				wait_drained();
			end
		end

		wait_drained();
		if (errors == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#40_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
src/dpq_pkg.sv
src/dpq_ram.sv
src/dpq_ctrl.sv
src/dpq_datapath.sv
src/double_ended_priority_queue_unit.sv
src/dpq_checker.sv
tb/dpq_checker.sv
tb/testbench.sv
